### hw/rtl/ps2mct_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse cursor tracker.
// No dependencies; every other file of the block refers to it by scoped name.
package ps2mct_pkg;

    // Byte, position and motion widths.
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 8;
    localparam int MOTION_W = 5;     // a signed byte divided by 8 lies in -16..15
    localparam int SUM_W    = 10;    // position plus or minus motion, with sign

    // The sync bit marks the first byte of a packet.
    localparam int SYNC_BIT_IDX = 3;

    // Motion is divided by 2**MOTION_SHIFT, truncating toward zero.
    localparam int MOTION_SHIFT = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW = 1'b1;

    // Reset values.
    localparam logic [POS_W-1:0] RESET_MAX_COL = 8'd79;
    localparam logic [POS_W-1:0] RESET_MAX_ROW = 8'd24;
    localparam logic [POS_W-1:0] RESET_COL     = 8'd40;
    localparam logic [POS_W-1:0] RESET_ROW     = 8'd12;

    // Packet assembly phase.
    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    // A packet handed from the assembler to the cursor update.
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
    } t_packet;

    // Signed motion byte divided by 8, rounding toward zero.
    function automatic logic signed [MOTION_W-1:0] motion_of(input logic [BYTE_W-1:0] b);
        logic signed [BYTE_W:0] v;
        v = $signed({b[BYTE_W-1], b});
        if (b[BYTE_W-1]) begin
            v = v + $signed((BYTE_W+1)'((1 << MOTION_SHIFT) - 1));
        end
        return v[MOTION_SHIFT+MOTION_W-1:MOTION_SHIFT];
    endfunction

    // Clamp a signed sum to 0..hi.
    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                   input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (v[SUM_W-2:0] > {1'b0, hi}) begin
            res = hi;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/ps2mct_packet.sv
// Packet assembler: tracks the three-byte phase and holds the X motion byte.
// Depends on ps2mct_pkg.
module ps2mct_packet (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_step,
    input  logic [ps2mct_pkg::BYTE_W-1:0]   i_byte,
    output ps2mct_pkg::t_packet             o_pkt
);

    ps2mct_pkg::t_phase r_phase, n_phase;
    logic [ps2mct_pkg::BYTE_W-1:0] r_dx, n_dx;

    // Next phase and held X byte.
    always_comb begin
        n_phase = r_phase;
        n_dx    = r_dx;
        if (i_step) begin
            unique case (r_phase)
                ps2mct_pkg::PH_X: begin
                    n_dx    = i_byte;
                    n_phase = ps2mct_pkg::PH_Y;
                end
                ps2mct_pkg::PH_Y: begin
                    n_phase = ps2mct_pkg::PH_SYNC;
                end
                default: begin
                    // Waiting for sync; an unused phase code behaves the same.
                    n_phase = i_byte[ps2mct_pkg::SYNC_BIT_IDX] ? ps2mct_pkg::PH_X
                                                               : ps2mct_pkg::PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ps2mct_pkg::PH_SYNC;
            r_dx    <= '0;
        end else begin
            r_phase <= n_phase;
            r_dx    <= n_dx;
        end
    end

    // Packet outputs: the third byte completes the packet.
    always_comb begin
        o_pkt.done = i_valid && (r_phase == ps2mct_pkg::PH_Y);
        o_pkt.dx   = r_dx;
        o_pkt.dy   = i_byte;
    end

    // A stepped packet always returns the phase to sync.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_pkt.done) |=> (r_phase == ps2mct_pkg::PH_SYNC))
        else $error("phase did not return to sync after a packet");

    // The X byte changes only when it is captured in phase X.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && (r_phase == ps2mct_pkg::PH_X)) |=> $stable(r_dx))
        else $error("held X byte changed outside phase X");

    // Phase X is entered only from a stepped sync byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase != ps2mct_pkg::PH_X) && !(i_step && i_byte[ps2mct_pkg::SYNC_BIT_IDX]))
        |=> (r_phase != ps2mct_pkg::PH_X))
        else $error("phase X entered without a sync byte");

endmodule

### hw/rtl/ps2mct_cursor.sv
// Cursor update: applies scaled packet motion to the position and clamps it.
// Depends on ps2mct_pkg.
module ps2mct_cursor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  ps2mct_pkg::t_packet            i_pkt,
    input  logic [ps2mct_pkg::POS_W-1:0]   i_max_col,
    input  logic [ps2mct_pkg::POS_W-1:0]   i_max_row,
    output logic [ps2mct_pkg::POS_W-1:0]   o_new_col,
    output logic [ps2mct_pkg::POS_W-1:0]   o_new_row
);

    logic [ps2mct_pkg::POS_W-1:0] r_col, r_row;
    logic signed [ps2mct_pkg::MOTION_W-1:0] w_mx, w_my;
    logic signed [ps2mct_pkg::SUM_W-1:0] w_sum_col, w_sum_row;

    // Scale motion and form the unclamped new position.
    always_comb begin
        w_mx = ps2mct_pkg::motion_of(i_pkt.dx);
        w_my = ps2mct_pkg::motion_of(i_pkt.dy);
        w_sum_col = $signed({{(ps2mct_pkg::SUM_W - ps2mct_pkg::POS_W){1'b0}}, r_col})
                  + $signed({{(ps2mct_pkg::SUM_W - ps2mct_pkg::MOTION_W)
                               {w_mx[ps2mct_pkg::MOTION_W-1]}}, w_mx});
        w_sum_row = $signed({{(ps2mct_pkg::SUM_W - ps2mct_pkg::POS_W){1'b0}}, r_row})
                  - $signed({{(ps2mct_pkg::SUM_W - ps2mct_pkg::MOTION_W)
                               {w_my[ps2mct_pkg::MOTION_W-1]}}, w_my});
        o_new_col = ps2mct_pkg::clamp_pos(w_sum_col, i_max_col);
        o_new_row = ps2mct_pkg::clamp_pos(w_sum_row, i_max_row);
    end

    // Position registers move only on a completed packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= ps2mct_pkg::RESET_COL;
            r_row <= ps2mct_pkg::RESET_ROW;
        end else if (i_step && i_pkt.done) begin
            r_col <= o_new_col;
            r_row <= o_new_row;
        end
    end

    // The position never moves without a completed packet.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_pkt.done) |=> ($stable(r_col) && $stable(r_row)))
        else $error("cursor moved without a packet");

    // A committed clamped result never exceeds the configured maximum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_pkt.done) |-> (o_new_col <= i_max_col) && (o_new_row <= i_max_row))
        else $error("clamped cursor beyond maximum");

    // A committed update lands in the position registers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_pkt.done) |=> (r_col == $past(o_new_col)) && (r_row == $past(o_new_row)))
        else $error("cursor update lost");

endmodule

### hw/rtl/ps2_mouse_cursor_tracker.sv
// PS/2 mouse cursor tracker, top level: input register, packet assembler,
// cursor update and result register. Depends on ps2mct_pkg, ps2mct_packet, ps2mct_cursor.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one received mouse byte per beat
//   on i_rx_byte. The third byte of a packet that began with a byte whose bit 3
//   is set produces one result beat on the output channel (o_valid / i_ready)
//   carrying the clamped cursor column and row; other bytes produce no result.
//   Once accepted, the third byte of a packet sits in the input register, and
//   its clamped update is loaded into the result register when the byte moves on.
//   Throughput: one byte per cycle while the receiver keeps up.
//   If the receiver stalls with a result held, bytes that produce no result
//   still flow through; a byte that completes the next packet waits in the
//   input register, and o_ready drops until the held result is taken.
//   Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) sets the column and row
//   maximums; write only while no beat is in flight.
//   Reset (synchronous, active low) empties both registers, restarts packet
//   sync, sets the cursor to column 40, row 12 and the maximums to 79 and 24.
module ps2_mouse_cursor_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ps2mct_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ps2mct_pkg::POS_W-1:0]        o_cursor_col,
    output logic [ps2mct_pkg::POS_W-1:0]        o_cursor_row,
    input  logic                                i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ps2mct_pkg::POS_W-1:0]        i_cfg_data
);

    logic                            r_in_valid;
    logic [ps2mct_pkg::BYTE_W-1:0]   r_in_byte;
    logic                            r_out_valid;
    logic [ps2mct_pkg::POS_W-1:0]    r_out_col, r_out_row;
    logic [ps2mct_pkg::POS_W-1:0]    r_max_col, r_max_row;
    ps2mct_pkg::t_packet             w_pkt;
    logic [ps2mct_pkg::POS_W-1:0]    w_new_col, w_new_row;
    logic                            w_adv;
    logic                            w_in_take;

    // The held byte moves on unless it completes a packet and the result slot is full.
    assign w_adv     = r_in_valid && (!w_pkt.done || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_adv;
    assign w_in_take = i_valid && o_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col <= ps2mct_pkg::RESET_MAX_COL;
            r_max_row <= ps2mct_pkg::RESET_MAX_ROW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ps2mct_pkg::CFG_MAX_COL: r_max_col <= i_cfg_data;
                ps2mct_pkg::CFG_MAX_ROW: r_max_row <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ps2mct_packet u_packet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_pkt   (w_pkt)
    );

    ps2mct_cursor u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_pkt     (w_pkt),
        .i_max_col (r_max_col),
        .i_max_row (r_max_row),
        .o_new_col (w_new_col),
        .o_new_row (w_new_row)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_pkt.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pkt.done) begin
            r_out_col <= w_new_col;
            r_out_row <= w_new_row;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

    // A held result is never overwritten before it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_pkt.done) |-> (!r_out_valid || i_ready))
        else $error("result overwritten while stalled");

    // A blocked input byte stays put.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("blocked input byte lost");

    // The input side stalls only behind a completing byte and a full result slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && w_pkt.done && r_out_valid && !i_ready))
        else $error("input stalled without cause");

endmodule
